>>> sv/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray-sphere intersection unit
// Widths of all intermediate values, the register index codes and the
// record that travels down the square-root cell chain.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;

  localparam int DIR_W  = FRAC_BITS + 2;
  localparam int RAD_W  = COORD_WIDTH - 1;
  localparam int D_W    = COORD_WIDTH + 1;
  localparam int P_W    = DIR_W + D_W;
  localparam int BSUM_W = P_W + 2;
  localparam int B_W    = BSUM_W - FRAC_BITS;
  localparam int SQD_W  = 2 * D_W;
  localparam int DD_W   = SQD_W + 2;
  localparam int R2_W   = 2 * RAD_W;
  localparam int LO_W   = (B_W + 1) / 2;
  localparam int HI_W   = B_W - LO_W;
  localparam int LL_W   = 2 * LO_W;
  localparam int HL_W   = HI_W + LO_W;
  localparam int HH_W   = 2 * HI_W;
  localparam int BB_W   = 2 * B_W;
  localparam int DISC_W = BB_W + 2;
  localparam int ROOT_W = DISC_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int T_W    = ROOT_W + 2;
  localparam int ADDR_W = 2;

  typedef enum logic [ADDR_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } rsi_reg_t;

  typedef struct packed {
    logic [DISC_W-1:0]       rad;
    logic [ROOT_W-1:0]       root;
    logic [REM_W-1:0]        rem;
    logic signed [B_W-1:0]   b;
    logic                    neg;
  } rsi_sq_t;

endpackage

>>> sv/ray_sphere_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit: pipelined ray-sphere intersection
// Takes one ray per cycle while the output is not stalled and returns hit
// flag and distance to the sphere held in the configuration registers.
// ----------------------------------------------------------------------------
// The unit accepts one ray in every cycle while the output is not stalled
// and returns one result per ray, in order. Between input and output lie
// seven arithmetic stages, a chain of 38 square-root cells that each
// resolve one root bit, and the output register. A stalled output holds
// the whole pipeline; in_ready follows out_ready whenever a result is
// waiting. Configuration writes take effect at once and must only be made
// while no ray is in flight.
module ray_sphere_intersect_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [rsi_pkg::ADDR_W-1:0]              cfg_addr,
  input  logic [rsi_pkg::COORD_WIDTH-1:0]         cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  in_origin_x,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  in_origin_y,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  in_origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]        in_dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]        in_dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]        in_dir_z,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_hit,
  output logic [rsi_pkg::RAD_W-1:0]               out_hit_distance
);

  logic signed [rsi_pkg::COORD_WIDTH-1:0] center_x_r, center_y_r, center_z_r;
  logic [rsi_pkg::RAD_W-1:0]              radius_r;
  logic                                   en;
  logic                                   vld_chain [rsi_pkg::ROOT_W+1];
  rsi_pkg::rsi_sq_t                       sq_chain  [rsi_pkg::ROOT_W+1];
  rsi_pkg::rsi_sq_t                       last;
  logic signed [rsi_pkg::T_W-1:0]         nb, s, near_t, far_t, t;
  logic                                   hit_nxt;
  logic [rsi_pkg::RAD_W-1:0]              dist_nxt;
  logic                                   out_valid_r, out_hit_r;
  logic [rsi_pkg::RAD_W-1:0]              out_hit_distance_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= rsi_pkg::RAD_W'(1) << rsi_pkg::FRAC_BITS;
    end else if (cfg_we) begin
      unique case (rsi_pkg::rsi_reg_t'(cfg_addr))
        rsi_pkg::REG_CENTER_X: center_x_r <= cfg_wdata;
        rsi_pkg::REG_CENTER_Y: center_y_r <= cfg_wdata;
        rsi_pkg::REG_CENTER_Z: center_z_r <= cfg_wdata;
        rsi_pkg::REG_RADIUS:   radius_r   <= cfg_wdata[rsi_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (in_valid && en),
    .origin_x (in_origin_x),
    .origin_y (in_origin_y),
    .origin_z (in_origin_z),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .center_z (center_z_r),
    .radius   (radius_r),
    .vld_o    (vld_chain[0]),
    .sq_o     (sq_chain[0])
  );

  for (genvar g = 0; g < rsi_pkg::ROOT_W; g++) begin : g_cell
    rsi_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_chain[g]),
      .cin   (sq_chain[g]),
      .vld_o (vld_chain[g+1]),
      .cout  (sq_chain[g+1])
    );
  end

  always_comb begin
    last   = sq_chain[rsi_pkg::ROOT_W];
    nb     = -rsi_pkg::T_W'(last.b);
    s      = $signed({2'b00, last.root});
    near_t = nb - s;
    far_t  = nb + s;
    t      = near_t[rsi_pkg::T_W-1] ? far_t : near_t;
    hit_nxt  = !last.neg && !t[rsi_pkg::T_W-1];
    if (!hit_nxt) begin
      dist_nxt = '0;
    end else if (t[rsi_pkg::T_W-2:rsi_pkg::RAD_W] != '0) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = t[rsi_pkg::RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_chain[rsi_pkg::ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r          <= hit_nxt;
      out_hit_distance_r <= dist_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_hit_distance_r;

endmodule

>>> sv/rsi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsi_sqrt_cell: one bit of the pipelined integer square root
// Takes two radicand bits, tries the next root bit and passes the partial
// root and remainder to the next cell.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  rsi_pkg::rsi_sq_t cin,
  output logic            vld_o,
  output rsi_pkg::rsi_sq_t cout
);

  logic [rsi_pkg::REM_W-1:0] rem_sh;
  logic [rsi_pkg::REM_W-1:0] trial;
  logic                      ge;
  rsi_pkg::rsi_sq_t          cell_nxt;
  rsi_pkg::rsi_sq_t          cell_r;
  logic                      vld_r;

  always_comb begin
    rem_sh = {cin.rem[rsi_pkg::REM_W-3:0], cin.rad[rsi_pkg::DISC_W-1 -: 2]};
    trial  = {cin.root, 2'b01};
    ge     = (rem_sh >= trial);
    cell_nxt      = cin;
    cell_nxt.rad  = {cin.rad[rsi_pkg::DISC_W-3:0], 2'b00};
    cell_nxt.root = {cin.root[rsi_pkg::ROOT_W-2:0], ge};
    cell_nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign vld_o = vld_r;
  assign cout  = cell_r;

endmodule

>>> sv/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front: discriminant pipeline
// Forms d, b = dir.d, d.d and radius squared, then the discriminant, over
// seven register stages, and hands the first square-root cell its record.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    vld_i,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  origin_x,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  origin_y,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]        dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]        dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]        dir_z,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  center_x,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  center_y,
  input  logic signed [rsi_pkg::COORD_WIDTH-1:0]  center_z,
  input  logic [rsi_pkg::RAD_W-1:0]               radius,
  output logic                                    vld_o,
  output rsi_pkg::rsi_sq_t                        sq_o
);

  logic [6:0] vld_r;

  logic signed [rsi_pkg::D_W-1:0]    d_r   [3];
  logic signed [rsi_pkg::DIR_W-1:0]  dir_r [3];
  logic signed [rsi_pkg::P_W-1:0]    p_r   [3];
  logic [rsi_pkg::SQD_W-1:0]         sq_r  [3];
  logic [rsi_pkg::R2_W-1:0]          r2_2_r, r2_3_r, r2_4_r, r2_5_r, r2_6_r;
  logic signed [rsi_pkg::BSUM_W-1:0] bsum_r;
  logic [rsi_pkg::DD_W-1:0]          dd_3_r, dd_4_r, dd_5_r, dd_6_r;
  logic signed [rsi_pkg::B_W-1:0]    b_4_r, b_5_r, b_6_r;
  logic [rsi_pkg::B_W-1:0]           bmag;
  logic [rsi_pkg::LL_W-1:0]          ll_r;
  logic [rsi_pkg::HL_W-1:0]          hl_r;
  logic [rsi_pkg::HH_W-1:0]          hh_r;
  logic [rsi_pkg::BB_W-1:0]          bb_r;
  logic [rsi_pkg::DISC_W-1:0]        disc_nxt;
  logic [rsi_pkg::DISC_W-1:0]        disc_r;
  logic signed [rsi_pkg::B_W-1:0]    b_7_r;

  assign bmag = b_4_r[rsi_pkg::B_W-1] ? rsi_pkg::B_W'(-b_4_r) : b_4_r;
  assign disc_nxt = rsi_pkg::DISC_W'(bb_r) + rsi_pkg::DISC_W'(r2_6_r)
                  - rsi_pkg::DISC_W'(dd_6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= rsi_pkg::D_W'(origin_x) - rsi_pkg::D_W'(center_x);
      d_r[1] <= rsi_pkg::D_W'(origin_y) - rsi_pkg::D_W'(center_y);
      d_r[2] <= rsi_pkg::D_W'(origin_z) - rsi_pkg::D_W'(center_z);
      dir_r[0] <= dir_x;
      dir_r[1] <= dir_y;
      dir_r[2] <= dir_z;
      for (int i = 0; i < 3; i++) begin
        p_r[i]  <= rsi_pkg::P_W'(dir_r[i]) * rsi_pkg::P_W'(d_r[i]);
        sq_r[i] <= rsi_pkg::SQD_W'(rsi_pkg::SQD_W'(d_r[i]) * rsi_pkg::SQD_W'(d_r[i]));
      end
      r2_2_r <= rsi_pkg::R2_W'(radius) * rsi_pkg::R2_W'(radius);
      bsum_r <= rsi_pkg::BSUM_W'(p_r[0]) + rsi_pkg::BSUM_W'(p_r[1])
              + rsi_pkg::BSUM_W'(p_r[2]);
      dd_3_r <= rsi_pkg::DD_W'(sq_r[0]) + rsi_pkg::DD_W'(sq_r[1])
              + rsi_pkg::DD_W'(sq_r[2]);
      r2_3_r <= r2_2_r;
      b_4_r  <= rsi_pkg::B_W'(bsum_r >>> rsi_pkg::FRAC_BITS);
      dd_4_r <= dd_3_r;
      r2_4_r <= r2_3_r;
      ll_r   <= rsi_pkg::LL_W'(bmag[rsi_pkg::LO_W-1:0])
              * rsi_pkg::LL_W'(bmag[rsi_pkg::LO_W-1:0]);
      hl_r   <= rsi_pkg::HL_W'(bmag[rsi_pkg::B_W-1:rsi_pkg::LO_W])
              * rsi_pkg::HL_W'(bmag[rsi_pkg::LO_W-1:0]);
      hh_r   <= rsi_pkg::HH_W'(bmag[rsi_pkg::B_W-1:rsi_pkg::LO_W])
              * rsi_pkg::HH_W'(bmag[rsi_pkg::B_W-1:rsi_pkg::LO_W]);
      b_5_r  <= b_4_r;
      dd_5_r <= dd_4_r;
      r2_5_r <= r2_4_r;
      bb_r   <= (rsi_pkg::BB_W'(hh_r) << (2 * rsi_pkg::LO_W))
              + (rsi_pkg::BB_W'(hl_r) << (rsi_pkg::LO_W + 1))
              + rsi_pkg::BB_W'(ll_r);
      b_6_r  <= b_5_r;
      dd_6_r <= dd_5_r;
      r2_6_r <= r2_5_r;
      disc_r <= disc_nxt;
      b_7_r  <= b_6_r;
    end
  end

  always_comb begin
    sq_o.rad  = disc_r;
    sq_o.root = '0;
    sq_o.rem  = '0;
    sq_o.b    = b_7_r;
    sq_o.neg  = disc_r[rsi_pkg::DISC_W-1];
  end

  assign vld_o = vld_r[6];

endmodule

>>> sv/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for the ray-sphere intersection unit
// Watches the top-level ports and is bound to every instance of the unit.
// ----------------------------------------------------------------------------
module rsi_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_hit,
  input logic [rsi_pkg::RAD_W-1:0]  out_hit_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit)
      && $stable(out_hit_distance))
    else $error("Stalled result changed before its transfer.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_distance == '0)
    else $error("A miss reported a nonzero distance.");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("Input stalled while the output could move.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result presented right after reset.");

endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_hit          (out_hit),
  .out_hit_distance (out_hit_distance)
);

>>> tb/tb_ray_sphere_intersect_unit.sv
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect_unit: self-checking bench for the ray-sphere unit
// Streams directed and random rays through several sphere settings, keeps
// a bit-exact prediction of hit flag and distance per ray, and compares
// every output transfer in order against it, with both sides stalling at random in all but one phase.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect_unit;

  localparam int ONE       = 1 << rsi_pkg::FRAC_BITS;
  localparam int RUN_LIMIT = 600000;
  localparam int DRAIN     = 60;

  typedef struct {
    logic signed [rsi_pkg::COORD_WIDTH-1:0] org [3];
    logic signed [rsi_pkg::DIR_W-1:0]       dir [3];
  } ray_t;

  typedef struct {
    logic                      hit;
    logic [rsi_pkg::RAD_W-1:0] distance;
  } hit_t;

  class hit_tracker;
    logic signed [rsi_pkg::COORD_WIDTH-1:0] center [3];
    logic [rsi_pkg::RAD_W-1:0]              radius;
    hit_t                                   expected_hits[$];
    int                                     errors;

    function new();
      center = '{0, 0, 0};
      radius = ONE;
      errors = 0;
    endfunction

    function void set_reg(rsi_pkg::rsi_reg_t idx, logic [rsi_pkg::COORD_WIDTH-1:0] val);
      case (idx)
        rsi_pkg::REG_CENTER_X: center[0] = val;
        rsi_pkg::REG_CENTER_Y: center[1] = val;
        rsi_pkg::REG_CENTER_Z: center[2] = val;
        rsi_pkg::REG_RADIUS:   radius = val[rsi_pkg::RAD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_ray(ray_t r);
      logic signed [127:0] d, dsum, dd, b, disc, nb, t;
      logic [127:0] root, cand;
      hit_t e;
      dsum = 0;
      dd = 0;
      for (int i = 0; i < 3; i++) begin
        d = r.org[i] - center[i];
        dsum = dsum + r.dir[i] * d;
        dd = dd + d * d;
      end
      b = dsum >>> rsi_pkg::FRAC_BITS;
      disc = b * b + {97'b0, radius} * {97'b0, radius} - dd;
      e.hit = 1'b0;
      e.distance = '0;
      if (disc >= 0) begin
        root = 0;
        for (int k = 63; k >= 0; k--) begin
          cand = root | (128'd1 << k);
          if (cand * cand <= disc) root = cand;
        end
        nb = -b;
        t = nb - $signed(root);
        if (t < 0) t = nb + $signed(root);
        if (t >= 0) begin
          e.hit = 1'b1;
          e.distance = (t > 128'sh7FFF_FFFF) ? {rsi_pkg::RAD_W{1'b1}}
                                             : t[rsi_pkg::RAD_W-1:0];
        end
      end
      expected_hits.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_hit(logic hit, logic [rsi_pkg::RAD_W-1:0] distance);
      hit_t e;
      if (expected_hits.size() == 0) begin
        report($sformatf("unexpected result hit=%0b distance=%0d", hit, distance));
      end else begin
        e = expected_hits.pop_front();
        if (hit !== e.hit)
          report($sformatf("hit got %0b want %0b", hit, e.hit));
        if (distance !== e.distance)
          report($sformatf("hit_distance got %0d want %0d", distance, e.distance));
      end
    endtask
  endclass

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   cfg_we = 1'b0;
  logic [rsi_pkg::ADDR_W-1:0]             cfg_addr = '0;
  logic [rsi_pkg::COORD_WIDTH-1:0]        cfg_wdata = '0;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic signed [rsi_pkg::COORD_WIDTH-1:0] in_origin_x = '0, in_origin_y = '0;
  logic signed [rsi_pkg::COORD_WIDTH-1:0] in_origin_z = '0;
  logic signed [rsi_pkg::DIR_W-1:0]       in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic                                   out_hit;
  logic [rsi_pkg::RAD_W-1:0]              out_hit_distance;

  hit_tracker tracker = new();
  bit         no_idle = 1'b0;
  bit         hold_go = 1'b0;
  int         hold_left = 0;
  int         cycles = 0;

  ray_sphere_intersect_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = 300;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = no_idle || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_hit(out_hit, out_hit_distance);
  end

  task write_reg(rsi_pkg::rsi_reg_t idx, logic [rsi_pkg::COORD_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_sphere(logic [rsi_pkg::COORD_WIDTH-1:0] cx, logic [rsi_pkg::COORD_WIDTH-1:0] cy,
                  logic [rsi_pkg::COORD_WIDTH-1:0] cz, logic [rsi_pkg::COORD_WIDTH-1:0] r);
    write_reg(rsi_pkg::REG_CENTER_X, cx);
    write_reg(rsi_pkg::REG_CENTER_Y, cy);
    write_reg(rsi_pkg::REG_CENTER_Z, cz);
    write_reg(rsi_pkg::REG_RADIUS, r);
  endtask

  task send_ray(ray_t r);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {in_origin_x, in_origin_y, in_origin_z} = {r.org[0], r.org[1], r.org[2]};
    {in_dir_x, in_dir_y, in_dir_z} = {r.dir[0], r.dir[1], r.dir[2]};
    do @(posedge clk); while (!in_ready);
    tracker.note_ray(r);
  endtask

  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function ray_t mk(longint ox, longint oy, longint oz, int dx, int dy, int dz);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    return r;
  endfunction

  function ray_t rand_ray();
    ray_t r;
    int a;
    longint off, span;
    if ($urandom_range(99) < 15) begin
      for (int i = 0; i < 3; i++) begin
        r.org[i] = $urandom();
        r.dir[i] = $urandom();
      end
    end else begin
      a = $urandom_range(2);
      span = longint'(tracker.radius) * 4 + ONE;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      for (int i = 0; i < 3; i++) begin
        off = (i == a) ? longint'($urandom_range(span)) - span / 2
                       : longint'($urandom_range(tracker.radius + 1)) -
                         longint'(tracker.radius) / 2;
        r.org[i] = longint'(tracker.center[i]) + off;
        r.dir[i] = int'($urandom_range(8191)) - 4096;
        if (i == a) begin
          r.dir[i] = (off > 0) ? -ONE : ONE;
          if ($urandom_range(9) < 3) r.dir[i] = -r.dir[i];
        end
      end
    end
    return r;
  endfunction

  initial begin
    ray_t directed[$];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed = '{
      mk(-5 * ONE, 0, 0, ONE, 0, 0), mk(5 * ONE, 0, 0, ONE, 0, 0),
      mk(0, 0, 0, 0, ONE, 0), mk(ONE / 2, 0, 0, 0, 0, -ONE),
      mk(-5 * ONE, ONE, 0, ONE, 0, 0), mk(0, -5 * ONE, ONE, 0, ONE, 0),
      mk(-5 * ONE, 2 * ONE, 0, ONE, 0, 0), mk(0, 0, 0, 0, 0, 0),
      mk(3 * ONE, 0, 0, 0, 0, 0), mk(-32'sh8000_0000, 0, 0, ONE, 0, 0),
      mk(32'sh7FFF_FFFF, 0, 0, -ONE, 0, 0),
      mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -ONE, -ONE, -ONE),
      mk(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, ONE, ONE, ONE),
      mk(-5 * ONE, 0, 0, 131071, -131072, 0), mk(0, 0, -4 * ONE, 0, 0, 131071),
      mk(0, 0, 4 * ONE, -131072, -131072, -131072), mk(0, 0, 0, -1, 1, -1),
      mk(-3 * ONE, -3 * ONE, 0, 46341, 46341, 0), mk(ONE, 0, 0, -ONE, 0, 0)
    };
    foreach (directed[i]) send_ray(directed[i]);
    repeat (340) send_ray(rand_ray());
    drain();

    no_idle = 1'b1;
    set_sphere($urandom_range(1 << 21) - (1 << 20), $urandom_range(1 << 21) - (1 << 20),
               $urandom_range(1 << 21) - (1 << 20), $urandom_range(1 << 22));
    repeat (200) send_ray(rand_ray());
    no_idle = 1'b0;
    repeat (160) send_ray(rand_ray());
    drain();

    set_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    repeat (60) send_ray(rand_ray());
    hold_go = 1'b1;
    repeat (300) send_ray(rand_ray());
    drain();

    set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    repeat (360) send_ray(rand_ray());
    drain();

    set_sphere($urandom(), $urandom(), $urandom(), $urandom_range(1 << 24));
    repeat (360) send_ray(rand_ray());
    drain();

    if (tracker.errors == 0 && tracker.expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/rsi_pkg.sv
sv/rsi_sqrt_cell.sv
sv/rsi_front.sv
sv/ray_sphere_intersect_unit.sv
sv/rsi_checker.sv
tb/tb_ray_sphere_intersect_unit.sv
